FILE: design/brm_pkg.sv
// Shared types, codes and helper functions for the byte register machine executor.
`default_nettype none

package brm_pkg;

    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int IDX_W     = 11;
    localparam int RF_DEPTH  = 8;
    localparam int RF_AW     = $clog2(RF_DEPTH);

    typedef enum logic [3:0] {
        K_ADD     = 4'd0,
        K_SUB     = 4'd1,
        K_AND     = 4'd2,
        K_OR      = 4'd3,
        K_NOT     = 4'd4,
        K_SHL     = 4'd5,
        K_SAR     = 4'd6,
        K_STORE   = 4'd7,
        K_LOAD    = 4'd8,
        K_JUMP    = 4'd9,
        K_SKIPCLR = 4'd10,
        K_SKIPSET = 4'd11,
        K_SKIPEQ  = 4'd12,
        K_READREG = 4'd13,
        K_READMEM = 4'd14,
        K_UNUSED  = 4'd15
    } kind_t;

    localparam logic [1:0] SEL_REG = 2'd0;
    localparam logic [1:0] SEL_IMM = 2'd1;

    typedef struct packed {
        logic [3:0]       kind;
        logic [RF_AW-1:0] dest_reg;
        logic [RF_AW-1:0] src_reg;
        logic [1:0]       src_select;
        logic [7:0]       immediate;
        logic [7:0]       mem_address;
        logic [IDX_W-1:0] jump_target;
    } instr_t;

    typedef struct packed {
        logic [IDX_W-1:0]  next_index;
        logic              skipped;
        logic signed [7:0] value_out;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    // amount outside 0..7 when negative or any bit above bit 2 is set
    function automatic logic amt_out_of_range(input logic [7:0] amt);
        return amt[7] | (|amt[6:3]);
    endfunction

    function automatic logic [7:0] shl8(input logic [7:0] v, input logic [7:0] amt);
        logic [7:0] res;
        if (amt_out_of_range(amt))
            res = 8'd0;
        else
            res = v << amt[2:0];
        return res;
    endfunction

    function automatic logic [7:0] sar8(input logic [7:0] v, input logic [7:0] amt);
        logic [7:0] res;
        if (amt_out_of_range(amt))
            res = {8{v[7]}};
        else
            res = $unsigned($signed(v) >>> amt[2:0]);
        return res;
    endfunction

    function automatic logic bit_test(input logic [7:0] v, input logic [7:0] idx);
        logic res;
        if (amt_out_of_range(idx))
            res = v[7];
        else
            res = v[idx[2:0]];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/brm_instr_if.sv
// Instruction channel: valid/ready handshake with the decoded instruction fields.
`default_nettype none

interface brm_instr_if;
    logic                        valid;
    logic                        ready;
    logic [3:0]                  kind;
    logic [brm_pkg::RF_AW-1:0]   dest_reg;
    logic [brm_pkg::RF_AW-1:0]   src_reg;
    logic [1:0]                  src_select;
    logic [7:0]                  immediate;
    logic [7:0]                  mem_address;
    logic [brm_pkg::IDX_W-1:0]   jump_target;

    modport source (
        output valid, kind, dest_reg, src_reg, src_select, immediate, mem_address,
               jump_target,
        input  ready
    );

    modport sink (
        input  valid, kind, dest_reg, src_reg, src_select, immediate, mem_address,
               jump_target,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/brm_result_if.sv
// Result channel: valid/ready handshake with next index, skip flag and value.
`default_nettype none

interface brm_result_if;
    logic                        valid;
    logic                        ready;
    logic [brm_pkg::IDX_W-1:0]   next_index;
    logic                        skipped;
    logic signed [7:0]           value_out;

    modport source (
        output valid, next_index, skipped, value_out,
        input  ready
    );

    modport sink (
        input  valid, next_index, skipped, value_out,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/brm_datapath.sv
// Datapath: register file, data memory, instruction index, ALU and result register.
`default_nettype none

module brm_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire brm_pkg::cmd_t    cmd,
    input  wire brm_pkg::instr_t  instr,
    output brm_pkg::result_t      result
);

    logic [7:0]                 rf_reg [brm_pkg::RF_DEPTH];
    logic [7:0]                 mem [brm_pkg::MEM_DEPTH];
    logic [brm_pkg::MEM_DEPTH-1:0] mem_vld_reg;
    logic [brm_pkg::IDX_W-1:0]  idx_reg;
    logic [brm_pkg::IDX_W-1:0]  idx_next;

    logic [3:0]                 kind_reg;
    logic [brm_pkg::RF_AW-1:0]  dst_reg;
    logic [1:0]                 sel_reg;
    logic [7:0]                 imm_reg;
    logic [7:0]                 addr_reg;
    logic [brm_pkg::IDX_W-1:0]  target_reg;
    logic [7:0]                 a_reg;
    logic [7:0]                 b_reg;
    logic [7:0]                 mem_rd_reg;
    logic                       mem_rd_vld_reg;

    brm_pkg::result_t           result_reg;
    brm_pkg::result_t           result_next;

    logic [7:0]                 mem_val;
    logic [7:0]                 val;
    logic                       wr_rf;
    logic                       wr_mem;
    logic                       skip;
    logic                       advance;
    logic [brm_pkg::IDX_W-1:0]  jump_idx;
    logic                       do_jump;

    // never-written memory bytes read as zero
    assign mem_val = mem_rd_vld_reg ? mem_rd_reg : 8'd0;

    always_comb
    begin
        val     = 8'd0;
        wr_rf   = 1'b0;
        wr_mem  = 1'b0;
        skip    = 1'b0;
        advance = 1'b1;
        do_jump = 1'b0;
        unique case (brm_pkg::kind_t'(kind_reg))
            brm_pkg::K_ADD:
            begin
                val   = a_reg + b_reg;
                wr_rf = 1'b1;
            end
            brm_pkg::K_SUB:
            begin
                val   = a_reg - b_reg;
                wr_rf = 1'b1;
            end
            brm_pkg::K_AND:
            begin
                val   = a_reg & b_reg;
                wr_rf = 1'b1;
            end
            brm_pkg::K_OR:
            begin
                val   = a_reg | b_reg;
                wr_rf = 1'b1;
            end
            brm_pkg::K_NOT:
            begin
                val   = ~a_reg;
                wr_rf = 1'b1;
            end
            brm_pkg::K_SHL:
            begin
                val   = brm_pkg::shl8(a_reg, b_reg);
                wr_rf = 1'b1;
            end
            brm_pkg::K_SAR:
            begin
                val   = brm_pkg::sar8(a_reg, b_reg);
                wr_rf = 1'b1;
            end
            brm_pkg::K_STORE:
            begin
                val    = (sel_reg == brm_pkg::SEL_REG) ? b_reg : imm_reg;
                wr_mem = 1'b1;
            end
            brm_pkg::K_LOAD:
            begin
                if (sel_reg == brm_pkg::SEL_REG)
                    val = b_reg;
                else if (sel_reg == brm_pkg::SEL_IMM)
                    val = imm_reg;
                else
                    val = mem_val;
                wr_rf = 1'b1;
            end
            brm_pkg::K_JUMP:    do_jump = 1'b1;
            brm_pkg::K_SKIPCLR: skip = ~brm_pkg::bit_test(a_reg, b_reg);
            brm_pkg::K_SKIPSET: skip = brm_pkg::bit_test(a_reg, b_reg);
            brm_pkg::K_SKIPEQ:  skip = (a_reg == b_reg);
            brm_pkg::K_READREG:
            begin
                val     = b_reg;
                advance = 1'b0;
            end
            brm_pkg::K_READMEM:
            begin
                val     = mem_val;
                advance = 1'b0;
            end
            default:            advance = 1'b0;
        endcase
    end

    assign jump_idx = target_reg;

    always_comb
    begin
        if (!advance)
            idx_next = idx_reg;
        else if (do_jump)
            idx_next = jump_idx;
        else if (skip)
            idx_next = idx_reg + brm_pkg::IDX_W'(2);
        else
            idx_next = idx_reg + brm_pkg::IDX_W'(1);
    end

    always_comb
    begin
        result_next.next_index = idx_next;
        result_next.skipped    = skip;
        result_next.value_out  = $signed(val);
    end

    // operand capture, register and memory reads at transaction acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg       <= instr.kind;
            dst_reg        <= instr.dest_reg;
            sel_reg        <= instr.src_select;
            imm_reg        <= instr.immediate;
            addr_reg       <= instr.mem_address;
            target_reg     <= instr.jump_target;
            a_reg          <= rf_reg[instr.dest_reg];
            b_reg          <= rf_reg[instr.src_reg];
            mem_rd_reg     <= mem[instr.mem_address];
            mem_rd_vld_reg <= mem_vld_reg[instr.mem_address];
        end
        if (cmd.commit)
            result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_mem)
            mem[addr_reg] <= val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg <= '0;
            idx_reg     <= '0;
            for (int i = 0; i < brm_pkg::RF_DEPTH; i++)
                rf_reg[i] <= 8'd0;
        end
        else if (cmd.commit)
        begin
            idx_reg <= idx_next;
            if (wr_mem)
                mem_vld_reg[addr_reg] <= 1'b1;
            if (wr_rf)
                rf_reg[dst_reg] <= val;
        end
    end

    assign result = result_reg;

    // instruction index only moves when an instruction retires
    a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(idx_reg))
        else $error("instruction index changed without commit");

    // read kinds leave the index where it was
    a_read_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (kind_reg == brm_pkg::K_READREG || kind_reg == brm_pkg::K_READMEM)
        |=> $stable(idx_reg) && result_reg.next_index == idx_reg)
        else $error("read kind advanced the instruction index");

    // skip flag only ever reported for skip kinds
    a_skip_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && skip |-> (kind_reg == brm_pkg::K_SKIPCLR ||
                                kind_reg == brm_pkg::K_SKIPSET ||
                                kind_reg == brm_pkg::K_SKIPEQ))
        else $error("skip raised by a non-skip kind");

endmodule

`default_nettype wire

FILE: design/brm_ctrl.sv
// Controller: accept/execute sequencing and result register occupancy.
`default_nettype none

module brm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output brm_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && in_ready;
    // retire only once the result register is free or being emptied
    assign cmd.commit  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (cmd.capture) state_next = S_EXEC;
            S_EXEC:  if (cmd.commit)  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = cmd.commit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_EXEC)
        else $error("captured instruction did not enter execute");

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit would overwrite a pending result");

    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("retired instruction produced no result");

    a_no_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");

endmodule

`default_nettype wire

FILE: design/byte_register_machine_executor.sv
// Top level of the byte register machine executor.
//
//   channel   dir   modport   payload
//   instr     in    sink      kind, dest_reg, src_reg, src_select, immediate,
//                             mem_address, jump_target
//   result    out   source    next_index, skipped, value_out
//
// Each instruction is first captured, with the register file and data memory
// read into registers, and then executed, loading the result register.
// A new instruction is taken while a result still waits; execution then holds
// until the result register empties. Asynchronous active-low reset clears the
// registers, instruction index and per-byte memory valid bits at once, so no
// clearing pass is needed.
`default_nettype none

module byte_register_machine_executor (
    input  wire logic     clk,
    input  wire logic     rst_n,
    brm_instr_if.sink     instr,
    brm_result_if.source  result
);

    brm_pkg::cmd_t    cmd;
    brm_pkg::instr_t  instr_pl;
    brm_pkg::result_t result_pl;

    always_comb
    begin
        instr_pl.kind        = instr.kind;
        instr_pl.dest_reg    = instr.dest_reg;
        instr_pl.src_reg     = instr.src_reg;
        instr_pl.src_select  = instr.src_select;
        instr_pl.immediate   = instr.immediate;
        instr_pl.mem_address = instr.mem_address;
        instr_pl.jump_target = instr.jump_target;
    end

    brm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (instr.valid),
        .in_ready  (instr.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    brm_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .instr  (instr_pl),
        .result (result_pl)
    );

    assign result.next_index = result_pl.next_index;
    assign result.skipped    = result_pl.skipped;
    assign result.value_out  = result_pl.value_out;

endmodule

`default_nettype wire

FILE: tb/sv/brm_exec_checker.sv
// Checker for the byte register machine executor: predicts each result and compares it.

module brm_exec_checker (
    input  logic        clk,
    input  logic        rst_n,
    brm_instr_if        instr,
    brm_result_if       result,
    output int          errors,
    output int          outstanding,
    output int          checked,
    output logic [15:0] kinds_seen
);

    // machine state as the executor should hold it
    logic [7:0]                gpr [0:brm_pkg::RF_DEPTH-1];
    logic [7:0]                dmem [0:brm_pkg::MEM_DEPTH-1];
    logic [brm_pkg::IDX_W-1:0] pc;

    brm_pkg::result_t expected_results [$];
    brm_pkg::result_t got;
    brm_pkg::result_t want;
    brm_pkg::instr_t  ins;
    int               err_cnt;
    int               checked_cnt;
    logic [15:0]      kind_mask;

    initial
    begin
        for (int i = 0; i < brm_pkg::RF_DEPTH; i++)
            gpr[i] = 8'h00;
        for (int i = 0; i < brm_pkg::MEM_DEPTH; i++)
            dmem[i] = 8'h00;
        pc          = '0;
        err_cnt     = 0;
        checked_cnt = 0;
        kind_mask   = '0;
    end

    // runs one instruction on the machine state and returns what the block should report
    function automatic brm_pkg::result_t execute_instr(input brm_pkg::instr_t op);
        logic [7:0]                a;
        logic [7:0]                b;
        logic [7:0]                v;
        logic [brm_pkg::IDX_W-1:0] nxt;
        logic                      skip;
        logic                      adv;
        int                        amt;
        int                        sa;
        logic [2:0]                bit_pos;
        brm_pkg::result_t          r;
        a    = gpr[op.dest_reg];
        b    = gpr[op.src_reg];
        v    = 8'h00;
        nxt  = pc + 1'b1;
        skip = 1'b0;
        adv  = 1'b1;
        amt  = int'($signed(b));
        sa   = int'($signed(a));
        // bit index outside 0..7 tests the sign bit
        bit_pos = (amt < 0 || amt > 7) ? 3'd7 : 3'(amt);
        case (brm_pkg::kind_t'(op.kind))
            brm_pkg::K_ADD: begin v = a + b; gpr[op.dest_reg] = v; end
            brm_pkg::K_SUB: begin v = a - b; gpr[op.dest_reg] = v; end
            brm_pkg::K_AND: begin v = a & b; gpr[op.dest_reg] = v; end
            brm_pkg::K_OR:  begin v = a | b; gpr[op.dest_reg] = v; end
            brm_pkg::K_NOT: begin v = ~a;    gpr[op.dest_reg] = v; end
            brm_pkg::K_SHL:
            begin
                if (amt < 0 || amt > 7)
                    v = 8'h00;
                else
                    v = a << amt;
                gpr[op.dest_reg] = v;
            end
            brm_pkg::K_SAR:
            begin
                if (amt < 0 || amt > 7)
                    v = a[7] ? 8'hFF : 8'h00;
                else
                    v = 8'(sa >>> amt);
                gpr[op.dest_reg] = v;
            end
            brm_pkg::K_STORE:
            begin
                v = (op.src_select == brm_pkg::SEL_REG) ? b : op.immediate;
                dmem[op.mem_address] = v;
            end
            brm_pkg::K_LOAD:
            begin
                if (op.src_select == brm_pkg::SEL_REG)
                    v = b;
                else if (op.src_select == brm_pkg::SEL_IMM)
                    v = op.immediate;
                else
                    v = dmem[op.mem_address];
                gpr[op.dest_reg] = v;
            end
            brm_pkg::K_JUMP:    nxt = op.jump_target;
            brm_pkg::K_SKIPCLR: skip = !a[bit_pos];
            brm_pkg::K_SKIPSET: skip = a[bit_pos];
            brm_pkg::K_SKIPEQ:  skip = (a == b);
            brm_pkg::K_READREG: begin v = b; adv = 1'b0; end
            brm_pkg::K_READMEM: begin v = dmem[op.mem_address]; adv = 1'b0; end
            default:            adv = 1'b0;
        endcase
        if (skip)
            nxt = pc + 2'd2;
        if (adv)
            pc = nxt;
        else
            nxt = pc;
        r.next_index = nxt;
        r.skipped    = skip;
        r.value_out  = v;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result first: a result can never belong to an instruction taken at the same edge
            if (result.valid && result.ready)
            begin
                got.next_index = result.next_index;
                got.skipped    = result.skipped;
                got.value_out  = result.value_out;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with none expected: next_index %0d value_out %0d",
                           got.next_index, got.value_out);
                    err_cnt++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked_cnt++;
                    if (got.next_index !== want.next_index)
                    begin
                        $error("next_index: expected %0d, got %0d", want.next_index,
                               got.next_index);
                        err_cnt++;
                    end
                    if (got.skipped !== want.skipped)
                    begin
                        $error("skipped: expected %0b, got %0b", want.skipped, got.skipped);
                        err_cnt++;
                    end
                    if (got.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %0d, got %0d", want.value_out,
                               got.value_out);
                        err_cnt++;
                    end
                end
            end
            if (instr.valid && instr.ready)
            begin
                ins.kind        = instr.kind;
                ins.dest_reg    = instr.dest_reg;
                ins.src_reg     = instr.src_reg;
                ins.src_select  = instr.src_select;
                ins.immediate   = instr.immediate;
                ins.mem_address = instr.mem_address;
                ins.jump_target = instr.jump_target;
                kind_mask[instr.kind] = 1'b1;
                expected_results.push_back(execute_instr(ins));
            end
        end
        errors      <= err_cnt;
        outstanding <= expected_results.size();
        checked     <= checked_cnt;
        kinds_seen  <= kind_mask;
    end

endmodule

FILE: tb/sv/tb_byte_register_machine_executor.sv
// Testbench top for the byte register machine executor: stimulus, back-pressure and verdict.

module tb_byte_register_machine_executor;

    localparam int         ITEM_TARGET = 1150;
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] SEL_MEM     = 2'd2;
    localparam logic [1:0] SEL_MEM_HI  = 2'd3;

    logic clk;
    logic rst_n;

    brm_instr_if  instr_ch ();
    brm_result_if result_ch ();

    int          errors;
    int          outstanding;
    int          checked;
    logic [15:0] kinds_seen;

    int   sent;
    int   cycles;
    int   stall_left;
    logic steady;

    byte_register_machine_executor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    brm_exec_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr       (instr_ch),
        .result      (result_ch),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .kinds_seen  (kinds_seen)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (steady || $urandom_range(0, 99) < 70)
            result_ch.ready <= 1'b1;
        else
        begin
            result_ch.ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
        end
    end

    task automatic send(input brm_pkg::kind_t k, input logic [2:0] d, input logic [2:0] s,
                        input logic [1:0] sel, input logic [7:0] imm,
                        input logic [7:0] addr, input logic [10:0] tgt);
        int gap;
        instr_ch.valid       <= 1'b1;
        instr_ch.kind        <= k;
        instr_ch.dest_reg    <= d;
        instr_ch.src_reg     <= s;
        instr_ch.src_select  <= sel;
        instr_ch.immediate   <= imm;
        instr_ch.mem_address <= addr;
        instr_ch.jump_target <= tgt;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        sent++;
        gap = idle_len();
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every outstanding result has come back
    task automatic drain();
        instr_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic send_random();
        brm_pkg::kind_t k;
        logic [2:0]     d;
        logic [2:0]     s;
        logic [1:0]     sel;
        logic [7:0]     imm;
        logic [7:0]     addr;
        logic [7:0]     amt;
        logic [10:0]    tgt;
        int             r;
        r = $urandom_range(0, 99);
        k = (r < 2) ? brm_pkg::K_UNUSED : brm_pkg::kind_t'($urandom_range(0, 14));
        d = 3'($urandom_range(0, 7));
        s = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        sel  = (r < 8) ? SEL_MEM_HI : 2'($urandom_range(0, 2));
        imm  = 8'($urandom_range(0, 255));
        // keep most addresses in a small window so reads hit written bytes
        addr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 15));
        tgt  = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                           : 11'($urandom_range(0, 1024));
        if ((k == brm_pkg::K_SHL || k == brm_pkg::K_SAR || k == brm_pkg::K_SKIPCLR ||
             k == brm_pkg::K_SKIPSET) && $urandom_range(0, 1) == 0)
        begin
            // set up a shift amount or bit index near the in-range boundary
            amt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(246, 255))
                                              : 8'($urandom_range(0, 10));
            send(brm_pkg::K_LOAD, s, d, brm_pkg::SEL_IMM, amt, addr, tgt);
        end
        else if (k == brm_pkg::K_SKIPEQ && $urandom_range(0, 9) < 4)
            send(brm_pkg::K_LOAD, s, d, brm_pkg::SEL_REG, imm, addr, tgt);
        send(k, d, s, sel, imm, addr, tgt);
    endtask

    initial
    begin
        int last_drain;
        rst_n                <= 1'b0;
        steady               <= 1'b0;
        sent                  = 0;
        last_drain            = 0;
        instr_ch.valid       <= 1'b0;
        instr_ch.kind        <= brm_pkg::K_ADD;
        instr_ch.dest_reg    <= '0;
        instr_ch.src_reg     <= '0;
        instr_ch.src_select  <= brm_pkg::SEL_REG;
        instr_ch.immediate   <= '0;
        instr_ch.mem_address <= '0;
        instr_ch.jump_target <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, wrap-around, shift and bit-index edges, every kind
        send(brm_pkg::K_LOAD,    0, 0, brm_pkg::SEL_IMM, 8'h7F, 8'h00, 11'd0);
        send(brm_pkg::K_LOAD,    1, 0, brm_pkg::SEL_IMM, 8'h80, 8'h00, 11'd0);
        send(brm_pkg::K_ADD,     0, 1, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_SUB,     1, 0, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_AND,     0, 1, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_OR,      1, 0, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_NOT,     2, 0, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_LOAD,    3, 0, brm_pkg::SEL_IMM, 8'h03, 8'h00, 11'd0);
        send(brm_pkg::K_SHL,     2, 3, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_SAR,     1, 3, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_LOAD,    4, 0, brm_pkg::SEL_IMM, 8'h08, 8'h00, 11'd0);
        send(brm_pkg::K_SHL,     0, 4, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_SAR,     1, 4, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_SHL,     3, 2, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_STORE,   0, 1, brm_pkg::SEL_REG, 8'h00, 8'hFF, 11'd0);
        send(brm_pkg::K_STORE,   0, 1, brm_pkg::SEL_IMM, 8'hA5, 8'h00, 11'd0);
        send(brm_pkg::K_STORE,   0, 1, SEL_MEM_HI,       8'h5A, 8'h80, 11'd0);
        send(brm_pkg::K_LOAD,    5, 0, SEL_MEM,          8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_LOAD,    6, 0, SEL_MEM_HI,       8'h00, 8'hFF, 11'd0);
        send(brm_pkg::K_READMEM, 0, 0, brm_pkg::SEL_REG, 8'h00, 8'h80, 11'd0);
        send(brm_pkg::K_READREG, 0, 5, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_JUMP,    0, 0, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd2047);
        send(brm_pkg::K_SKIPCLR, 1, 4, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_SKIPSET, 2, 3, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_SKIPEQ,  0, 0, brm_pkg::SEL_REG, 8'h00, 8'h00, 11'd0);
        send(brm_pkg::K_UNUSED,  7, 7, SEL_MEM_HI,       8'hFF, 8'hFF, 11'd2047);
        drain();

        while (sent < ITEM_TARGET)
        begin
            if (sent - last_drain >= 250)
            begin
                drain();
                last_drain = sent;
            end
            // one stretch with no idling on either side
            steady <= (sent >= 500 && sent < 650);
            send_random();
        end
        drain();
        steady <= 1'b0;
        // catch any stray result transactions
        repeat (40) @(posedge clk);

        $display("Issued %0d instructions, %0d results checked in %0d cycles",
                 sent, checked, cycles);
        $display("%0d of 16 kinds seen, with wraps, skips, jumps and out-of-range shifts",
                 $countones(kinds_seen));
        if (errors == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
